/* sv/tts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, character codes and character-class helpers of the token
// scanner.
// ----------------------------------------------------------------------------
package tts_pkg;

	localparam int CFG_W = 12;
	localparam logic [CFG_W-1:0] MAX_LEN_RESET = 12'd4095;

	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_SLASH   = 4'd1,
		M_COMMENT = 4'd2,
		M_IDENT   = 4'd3,
		M_STR     = 4'd4,
		M_ESC     = 4'd5,
		M_DEC     = 4'd6,
		M_INT     = 4'd7,
		M_FRAC    = 4'd8,
		M_EXP     = 4'd9,
		M_EXPD    = 4'd10,
		M_ERR     = 4'd11
	} mode_t;

	typedef enum logic [2:0] {
		K_IDENT = 3'd0,
		K_STR   = 3'd1,
		K_NUM   = 3'd2,
		K_PUNCT = 3'd3,
		K_END   = 3'd4,
		K_ERR   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		E_NONE    = 2'd0,
		E_LONG    = 2'd1,
		E_UNTERM  = 2'd2,
		E_BADCHAR = 2'd3
	} err_t;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_HT     = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_B   = 8'h62;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       data_valid;
		logic       token_end;
		err_t       err;
	} item_t;

	// all results caused by one text byte, item[0] delivered first
	typedef struct packed {
		logic [1:0]      count;
		item_t [2:0]     item;
	} group_t;

	function automatic item_t mk_item(kind_t k, logic [7:0] d, logic v, logic e, err_t er);
		item_t it;
		it.kind       = k;
		it.data       = d;
		it.data_valid = v;
		it.token_end  = e;
		it.err        = er;
		return it;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) || (c == CH_RPAREN);
	endfunction

	function automatic logic is_exp(logic [7:0] c);
		return (c == CH_LO_E) || (c == CH_UP_E);
	endfunction

endpackage : tts_pkg
`default_nettype wire

/* sv/tts_lex.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_lex
// Scanner state registers and the one-byte transition: from the current mode
// and a text byte, builds the group of up to three result beats.
// ----------------------------------------------------------------------------
module tts_lex
	import tts_pkg::*;
#(
	parameter int LEN_W = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step_en,
	input  wire logic [7:0]       c,
	input  wire logic             text_end,
	input  wire logic [CFG_W-1:0] max_len,
	input  wire logic [CFG_W-1:0] lim_cap,
	output group_t                grp
);

	mode_t            mode_q, mode_v;
	logic             qs_q, qs_v;
	logic [LEN_W-1:0] len_q, len_v;
	logic [6:0]       esc_q, esc_v;

	localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

	logic [CMP_W-1:0] lim_wide;
	logic [LEN_W-1:0] lim;
	logic             eot;

	logic       run_start, run_str, app_en;
	kind_t      app_kind;
	mode_t      app_next;
	logic [1:0] cnt;
	logic [7:0] term;
	logic [10:0] dec_acc;
	logic [7:0]  esc_out;

	// limit in force is min(register, capacity - 1); lim_cap carries capacity - 1
	// when it fits in the register width
	always_comb begin
		if (CMP_W'(max_len) > CMP_W'(lim_cap) && LEN_W <= CFG_W) begin
			lim_wide = CMP_W'(lim_cap);
		end else begin
			lim_wide = CMP_W'(max_len);
		end
		lim = lim_wide[LEN_W-1:0];
	end

	assign eot = text_end || (c == CH_NUL);

	always_comb begin
		mode_v    = mode_q;
		qs_v      = qs_q;
		len_v     = len_q;
		esc_v     = esc_q;
		grp       = '0;
		cnt       = 2'd0;
		run_start = 1'b0;
		run_str   = 1'b0;
		app_en    = 1'b0;
		app_kind  = K_IDENT;
		app_next  = M_IDLE;
		term      = CH_DQUOTE;
		dec_acc   = '0;
		esc_out   = c;

		if (eot) begin
			case (mode_q)
				M_IDENT: begin
					grp.item[cnt] = mk_item(K_IDENT, 8'd0, 1'b0, 1'b1, E_NONE);
					cnt = cnt + 2'd1;
				end
				M_INT, M_FRAC, M_EXP, M_EXPD: begin
					grp.item[cnt] = mk_item(K_NUM, 8'd0, 1'b0, 1'b1, E_NONE);
					cnt = cnt + 2'd1;
				end
				M_STR, M_ESC, M_DEC: begin
					grp.item[cnt] = mk_item(K_ERR, 8'd0, 1'b0, 1'b1, E_UNTERM);
					cnt = cnt + 2'd1;
				end
				M_SLASH: begin
					grp.item[cnt] = mk_item(K_ERR, 8'd0, 1'b0, 1'b1, E_BADCHAR);
					cnt = cnt + 2'd1;
				end
				default: ;
			endcase
			grp.item[cnt] = mk_item(K_END, 8'd0, 1'b0, 1'b1, E_NONE);
			cnt    = cnt + 2'd1;
			mode_v = M_IDLE;
			qs_v   = 1'b0;
			len_v  = '0;
			esc_v  = '0;
		end else begin
			unique case (mode_q)
				M_IDLE: run_start = 1'b1;
				M_SLASH: begin
					if (c == CH_SLASH) begin
						mode_v = M_COMMENT;
					end else begin
						grp.item[cnt] = mk_item(K_ERR, 8'd0, 1'b0, 1'b1, E_BADCHAR);
						cnt    = cnt + 2'd1;
						mode_v = M_ERR;
						len_v  = '0;
					end
				end
				M_COMMENT: begin
					if (c == CH_LF) mode_v = M_IDLE;
				end
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == CH_USCORE) begin
						app_en = 1'b1; app_kind = K_IDENT; app_next = M_IDENT;
					end else begin
						grp.item[cnt] = mk_item(K_IDENT, 8'd0, 1'b0, 1'b1, E_NONE);
						cnt = cnt + 2'd1;
						run_start = 1'b1;
					end
				end
				M_STR: run_str = 1'b1;
				M_ESC: begin
					if (is_digit(c)) begin
						esc_v  = 7'(c - CH_ZERO);
						mode_v = M_DEC;
					end else begin
						case (c)
							CH_LO_N: esc_out = CH_LF;
							CH_LO_R: esc_out = CH_CR;
							CH_LO_T: esc_out = CH_HT;
							CH_LO_B: esc_out = CH_BS;
							CH_LO_A: esc_out = CH_BEL;
							default: esc_out = c;
						endcase
						grp.item[cnt] = mk_item(K_STR, esc_out, 1'b1, 1'b0, E_NONE);
						cnt    = cnt + 2'd1;
						len_v  = len_v + LEN_W'(1);
						mode_v = M_STR;
					end
				end
				M_DEC: begin
					if (is_digit(c)) begin
						dec_acc = {1'b0, esc_q, 3'b000} + {3'b000, esc_q, 1'b0}
							+ {3'b000, c - CH_ZERO};
						esc_v = dec_acc[6:0];
					end else begin
						grp.item[cnt] = mk_item(K_STR, {1'b0, esc_q}, 1'b1, 1'b0, E_NONE);
						cnt     = cnt + 2'd1;
						len_v   = len_v + LEN_W'(1);
						esc_v   = '0;
						mode_v  = M_STR;
						run_str = 1'b1;
					end
				end
				M_INT: begin
					if (is_digit(c)) begin
						app_en = 1'b1; app_kind = K_NUM; app_next = M_INT;
					end else if (c == CH_DOT) begin
						app_en = 1'b1; app_kind = K_NUM; app_next = M_FRAC;
					end else if (is_exp(c)) begin
						app_en = 1'b1; app_kind = K_NUM; app_next = M_EXP;
					end else begin
						grp.item[cnt] = mk_item(K_NUM, 8'd0, 1'b0, 1'b1, E_NONE);
						cnt = cnt + 2'd1;
						run_start = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_digit(c)) begin
						app_en = 1'b1; app_kind = K_NUM; app_next = M_FRAC;
					end else if (is_exp(c)) begin
						app_en = 1'b1; app_kind = K_NUM; app_next = M_EXP;
					end else begin
						grp.item[cnt] = mk_item(K_NUM, 8'd0, 1'b0, 1'b1, E_NONE);
						cnt = cnt + 2'd1;
						run_start = 1'b1;
					end
				end
				M_EXP: begin
					if (is_digit(c) || c == CH_PLUS || c == CH_MINUS) begin
						app_en = 1'b1; app_kind = K_NUM; app_next = M_EXPD;
					end else begin
						grp.item[cnt] = mk_item(K_NUM, 8'd0, 1'b0, 1'b1, E_NONE);
						cnt = cnt + 2'd1;
						run_start = 1'b1;
					end
				end
				M_EXPD: begin
					if (is_digit(c)) begin
						app_en = 1'b1; app_kind = K_NUM; app_next = M_EXPD;
					end else begin
						grp.item[cnt] = mk_item(K_NUM, 8'd0, 1'b0, 1'b1, E_NONE);
						cnt = cnt + 2'd1;
						run_start = 1'b1;
					end
				end
				default: mode_v = M_ERR;
			endcase

			// string body character, also reached after a decimal escape closes
			if (run_str) begin
				term = qs_v ? CH_SQUOTE : CH_DQUOTE;
				if (c == term) begin
					grp.item[cnt] = mk_item(K_STR, 8'd0, 1'b0, 1'b1, E_NONE);
					cnt    = cnt + 2'd1;
					mode_v = M_IDLE;
					len_v  = '0;
				end else if (len_v >= lim) begin
					grp.item[cnt] = mk_item(K_ERR, 8'd0, 1'b0, 1'b1, E_LONG);
					cnt    = cnt + 2'd1;
					mode_v = M_ERR;
					len_v  = '0;
				end else if (c == CH_BSLASH) begin
					mode_v = M_ESC;
				end else begin
					grp.item[cnt] = mk_item(K_STR, c, 1'b1, 1'b0, E_NONE);
					cnt   = cnt + 2'd1;
					len_v = len_v + LEN_W'(1);
				end
			end

			// first character of a new token
			if (run_start) begin
				len_v  = '0;
				mode_v = M_IDLE;
				if (is_space(c)) begin
					mode_v = M_IDLE;
				end else if (c == CH_SLASH) begin
					mode_v = M_SLASH;
				end else if (is_punct(c)) begin
					grp.item[cnt] = mk_item(K_PUNCT, c, 1'b1, 1'b0, E_NONE);
					cnt = cnt + 2'd1;
					grp.item[cnt] = mk_item(K_PUNCT, 8'd0, 1'b0, 1'b1, E_NONE);
					cnt = cnt + 2'd1;
				end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
					qs_v   = (c == CH_SQUOTE);
					mode_v = M_STR;
				end else if (is_alpha(c)) begin
					app_en = 1'b1; app_kind = K_IDENT; app_next = M_IDENT;
				end else if (is_digit(c) || c == CH_MINUS) begin
					app_en = 1'b1; app_kind = K_NUM; app_next = M_INT;
				end else begin
					grp.item[cnt] = mk_item(K_ERR, 8'd0, 1'b0, 1'b1, E_BADCHAR);
					cnt    = cnt + 2'd1;
					mode_v = M_ERR;
				end
			end

			// append a content byte, or fail on length
			if (app_en) begin
				if (len_v >= lim) begin
					grp.item[cnt] = mk_item(K_ERR, 8'd0, 1'b0, 1'b1, E_LONG);
					cnt    = cnt + 2'd1;
					mode_v = M_ERR;
					len_v  = '0;
				end else begin
					grp.item[cnt] = mk_item(app_kind, c, 1'b1, 1'b0, E_NONE);
					cnt    = cnt + 2'd1;
					len_v  = len_v + LEN_W'(1);
					mode_v = app_next;
				end
			end
		end
		grp.count = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			qs_q   <= 1'b0;
			len_q  <= '0;
			esc_q  <= '0;
		end else if (step_en) begin
			mode_q <= mode_v;
			qs_q   <= qs_v;
			len_q  <= len_v;
			esc_q  <= esc_v;
		end
	end

`ifndef SYNTHESIS
	a_len_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_IDLE || mode_q == M_ERR || mode_q == M_SLASH || mode_q == M_COMMENT)
			|-> (len_q == '0))
		else $error("token length not cleared outside a token");
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && eot) |=> (mode_q == M_IDLE && !qs_q && esc_q == '0))
		else $error("end of text did not return scanner to idle");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && !eot && mode_q == M_ERR) |-> (grp.count == 2'd0))
		else $error("results emitted in error state");
`endif

endmodule : tts_lex
`default_nettype wire

/* sv/tts_obuf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_obuf
// Result register: holds the group of beats caused by one byte and hands
// them out one per cycle while out_ready is high, oldest first.
// ----------------------------------------------------------------------------
module tts_obuf
	import tts_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  group_t    grp,
	output logic      can_load,
	output logic      out_valid,
	input  wire logic out_ready,
	output item_t     out_item,
	output logic      out_last
);

	item_t [2:0] item_q;
	logic  [1:0] left_q;
	logic        pop;

	assign out_valid = (left_q != 2'd0);
	assign pop       = out_valid && out_ready;
	// take the next group once the last held beat leaves
	assign can_load  = (left_q == 2'd0) || (left_q == 2'd1 && out_ready);
	assign out_item  = item_q[0];
	assign out_last  = (left_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 2'd0;
		end else if (load && can_load) begin
			left_q <= grp.count;
		end else if (pop) begin
			left_q <= left_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			item_q <= grp.item;
		end else if (pop) begin
			item_q[0] <= item_q[1];
			item_q[1] <= item_q[2];
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !can_load) |=> ($stable(left_q) || $past(pop)))
		else $error("group loaded over pending beats");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(load && can_load) |=> (left_q == $past(grp.count)))
		else $error("beat count not taken from group");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !load) |=> (left_q == $past(left_q) - 2'd1))
		else $error("beat count not advanced on pop");
`endif

endmodule : tts_obuf
`default_nettype wire

/* sv/text_token_scanner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_token_scanner
// Byte-stream lexer: skips whitespace and line comments and emits token
// content bytes, token close beats, error beats and an end-of-text beat.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata          | tuser                                  | tlast
//  s_*      | in  | [7:0] in_byte  | -                                      | end_of_text
//  m_*      | out | [7:0] out_byte | [2:0] kind [3] byte_valid [5:4] error  | token_end
//           |     |                | [6] last_result                        |
//  cfg_*    | in  | cfg_wdata[11:0] max_token_len, written when cfg_we       |
//
// A byte beat is registered, then scanned combinationally into a result register.
// Its first result leaves from the result register once loaded. A byte that yields
// n results holds the result register until all n have left, so one byte
// per cycle is taken while each byte yields at most one result and m_tready is high.
// Reset clears the scanner to idle and max_token_len to 4095. s_tready stays
// high through output stalls until both the byte register and result register hold.
// ----------------------------------------------------------------------------
module text_token_scanner
	import tts_pkg::*;
#(
	parameter int MAX_TOKEN_BYTES = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,   // max_token_len
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [7:0]       s_tdata,     // [7:0] in_byte
	input  wire logic             s_tlast,     // end_of_text
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata,     // [7:0] out_byte
	output logic [6:0]            m_tuser,     // [2:0] token_kind, [3] byte_valid,
	                                           // [5:4] error_code, [6] last_result
	output logic                  m_tlast      // token_end
);

	localparam int LEN_W = $clog2(MAX_TOKEN_BYTES);
	localparam int CAP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
	localparam logic [CAP_W-1:0] CAP_WIDE = CAP_W'(MAX_TOKEN_BYTES - 1);
	localparam logic [CFG_W-1:0] LIM_CAP = (LEN_W > CFG_W) ? MAX_LEN_RESET
		: CAP_WIDE[CFG_W-1:0];

	logic [CFG_W-1:0] max_len_q;
	logic             s1_valid;
	logic [7:0]       byte_s1;
	logic             eot_s1;
	logic             advance;
	logic             can_load;
	group_t           grp;
	item_t            out_item;
	logic             out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	assign advance  = s1_valid && can_load;
	assign s_tready = !s1_valid || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	tts_lex #(
		.LEN_W(LEN_W)
	) u_lex (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (advance),
		.c        (byte_s1),
		.text_end (eot_s1),
		.max_len  (max_len_q),
		.lim_cap  (LIM_CAP),
		.grp      (grp)
	);

	tts_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.grp       (grp),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item),
		.out_last  (out_last)
	);

	assign m_tdata = out_item.data;
	assign m_tuser = {out_last, out_item.err, out_item.data_valid, out_item.kind};
	assign m_tlast = out_item.token_end;

`ifndef SYNTHESIS
	a_byte_not_close: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[3]) |-> (!m_tlast && m_tuser[5:4] == E_NONE))
		else $error("content beat marked as close or error");
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2:0] == K_ERR) |-> (m_tuser[5:4] != E_NONE && m_tlast))
		else $error("error beat without error code");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2:0] == K_END) |-> m_tuser[6])
		else $error("end-of-text beat not the final beat of its byte");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !advance) |=> (s1_valid && $stable(byte_s1) && $stable(eot_s1)))
		else $error("held byte lost before scan");
`endif

endmodule : text_token_scanner
`default_nettype wire
